/* rtl/core/arc_pkg.sv */
`default_nettype none

package arc_pkg;

    // Base codes, shared by the input and output tuser fields.
    typedef logic [1:0] base_t;

    localparam base_t BASE_BIN       = 2'd0;
    localparam base_t BASE_DEC       = 2'd1;
    localparam base_t BASE_HEX       = 2'd2;
    // The spare code on the input behaves as hexadecimal.
    localparam base_t BASE_HEX_ALIAS = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CHAR_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_LO_F  = 8'h66;  // 'f'
    localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UP_F  = 8'h46;  // 'F'
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    // Control from the sequencer to the decimal digit stack.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [3:0] digit;
    } stk_ctrl_t;

    // Value of one ASCII character in the given base; anything that is not
    // a digit of that base counts as zero. Base code three behaves as hex.
    function automatic logic [3:0] digit_of(input logic [7:0] c, input base_t base);
        logic [7:0] tmp;
        logic [3:0] d;
        tmp = 8'd0;
        d   = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            tmp = c - CHAR_ZERO;
            d   = tmp[3:0];
            if (base == BASE_BIN && d > 4'd1) begin
                d = 4'd0;
            end
        end
        else if (base == BASE_HEX || base == BASE_HEX_ALIAS) begin
            if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
                tmp = c - CHAR_LO_A + DIGIT_TEN;
                d   = tmp[3:0];
            end
            else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
                tmp = c - CHAR_UP_A + DIGIT_TEN;
                d   = tmp[3:0];
            end
        end
        return d;
    endfunction

    // ASCII form of a digit, lower case for ten and above.
    function automatic logic [7:0] ascii_of(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'b0000, d};
        end
        else begin
            c = CHAR_LO_A + {4'b0000, d} - DIGIT_TEN;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ascii_radix_converter_core.sv */
// ASCII radix converter.
// The slave stream takes a numeral one character per transaction: tdata is
// the ASCII character, tuser its base (0 binary, 1 decimal, 2 hexadecimal;
// 3 counts as hexadecimal) and tlast marks the numeral's last character.
// Every character is folded into the running value by Horner's rule in the
// cycle it is accepted, so characters of a numeral go in one per cycle.
// After the last character the block emits the value in the other two
// bases on the master stream, one ASCII digit per transaction, most
// significant first and without leading zeros: tdata is the digit, tuser
// holds the base and a flag on the last digit of each representation, and
// tlast marks the last digit of the whole run.
// Each representation starts in a load state. Binary and hex digits then
// come off a shift register: a skip state drops the leading zeros and an
// emit state sends the digits. Decimal digits come from a bit-serial
// divide-by-ten loop that pushes each remainder onto a digit stack, least
// significant first; once the quotient is zero the stack is popped.
// No new character is accepted until the run has been handed to the output
// register; a stall on the master side simply holds the sequencer.
// Reset clears the running value, empties the output register and leaves
// the block ready for the first character.
`default_nettype none

module ascii_radix_converter_core #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // slave stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] char_code
    input  wire arc_pkg::base_t    s_axis_tuser,   // [1:0] in_base
    input  wire logic              s_axis_tlast,   // final_char
    // master stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] out_char
    output logic [2:0]             m_axis_tuser,   // [1:0] out_base, [2] repr_end
    output logic                   m_axis_tlast    // run_end
);
    import arc_pkg::*;

    localparam int VB         = VALUE_BITS;
    localparam int HEX_DIGITS = (VB + 3) / 4;
    localparam int SW         = HEX_DIGITS * 4;
    localparam int CW         = $clog2(VB);
    // Decimal digits needed for a VB-bit value: floor(VB * log10(2)) + 1.
    localparam int DEC_DIGITS = (VB * 30103) / 100000 + 1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_LOAD,
        ST_SKIP,
        ST_EMIT,
        ST_DIV,
        ST_POP
    } state_t;

    state_t        state_reg,  state_next;
    logic [VB-1:0] acc_reg,    acc_next;
    logic [VB-1:0] val_reg,    val_next;
    logic [SW-1:0] sh_reg,     sh_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic [3:0]    rem_reg,    rem_next;
    logic          rep_reg,    rep_next;
    base_t         base_a_reg, base_a_next;
    base_t         base_b_reg, base_b_next;
    logic          ovalid_reg, ovalid_next;
    logic [7:0]    ochar_reg,  ochar_next;
    base_t         obase_reg,  obase_next;
    logic          orend_reg,  orend_next;
    logic          olast_reg,  olast_next;

    stk_ctrl_t     stk_ctrl;
    logic [3:0]    stk_top;
    logic          stk_last;

    base_t         cur_base;
    logic          out_free;
    logic          in_accept;
    logic [VB-1:0] horner;
    logic [3:0]    top_digit;
    logic [SW-1:0] shifted;
    logic [4:0]    div_trial;
    logic          div_ge;
    logic [4:0]    div_rem;
    logic [VB-1:0] div_quot;

    arc_dec_stack #(
        .DEPTH (DEC_DIGITS)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stk_ctrl),
        .top   (stk_top),
        .last  (stk_last)
    );

    assign cur_base  = rep_reg ? base_b_reg : base_a_reg;
    assign out_free  = !ovalid_reg || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Horner step; the sums wrap at VB bits.
    always_comb
    begin
        priority if (s_axis_tuser == BASE_BIN) begin
            horner = (acc_reg << 1) + VB'(digit_of(s_axis_tdata, s_axis_tuser));
        end
        else if (s_axis_tuser == BASE_DEC) begin
            horner = (acc_reg << 3) + (acc_reg << 1)
                   + VB'(digit_of(s_axis_tdata, s_axis_tuser));
        end
        else begin
            horner = (acc_reg << 4) + VB'(digit_of(s_axis_tdata, s_axis_tuser));
        end
    end

    // Most significant digit still in the shift register, and the shift
    // that drops it.
    always_comb
    begin
        if (cur_base == BASE_BIN) begin
            top_digit = {3'b000, sh_reg[VB-1]};
            shifted   = sh_reg << 1;
        end
        else begin
            top_digit = sh_reg[SW-1 -: 4];
            shifted   = sh_reg << 4;
        end
    end

    // One step of restoring division by ten, quotient bits entering at the
    // bottom as the dividend leaves at the top.
    assign div_trial = {rem_reg, sh_reg[VB-1]};
    assign div_ge    = (div_trial >= 5'd10);
    assign div_rem   = div_ge ? (div_trial - 5'd10) : div_trial;
    assign div_quot  = {sh_reg[VB-2:0], div_ge};

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        val_next    = val_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        rep_next    = rep_reg;
        base_a_next = base_a_reg;
        base_b_next = base_b_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        ochar_next  = ochar_reg;
        obase_next  = obase_reg;
        orend_next  = orend_reg;
        olast_next  = olast_reg;
        stk_ctrl    = '0;

        unique case (state_reg)
            ST_ACC:
            begin
                if (in_accept) begin
                    acc_next = horner;
                    if (s_axis_tlast) begin
                        val_next = horner;
                        acc_next = '0;
                        rep_next = 1'b0;
                        priority if (s_axis_tuser == BASE_BIN) begin
                            base_a_next = BASE_DEC;
                            base_b_next = BASE_HEX;
                        end
                        else if (s_axis_tuser == BASE_DEC) begin
                            base_a_next = BASE_HEX;
                            base_b_next = BASE_BIN;
                        end
                        else begin
                            base_a_next = BASE_DEC;
                            base_b_next = BASE_BIN;
                        end
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_LOAD:
            begin
                sh_next  = SW'(val_reg);
                rem_next = 4'd0;
                priority if (cur_base == BASE_DEC) begin
                    cnt_next   = CW'(VB - 1);
                    state_next = ST_DIV;
                end
                else if (cur_base == BASE_HEX) begin
                    cnt_next   = CW'(HEX_DIGITS - 1);
                    state_next = ST_SKIP;
                end
                else begin
                    cnt_next   = CW'(VB - 1);
                    state_next = ST_SKIP;
                end
            end

            ST_SKIP:
            begin
                // Drop leading zeros, but always keep the last digit.
                if (top_digit == 4'd0 && cnt_reg != '0) begin
                    sh_next  = shifted;
                    cnt_next = cnt_reg - CW'(1);
                end
                else begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = ascii_of(top_digit);
                    obase_next  = cur_base;
                    orend_next  = (cnt_reg == '0);
                    olast_next  = (cnt_reg == '0) && rep_reg;
                    sh_next     = shifted;
                    cnt_next    = cnt_reg - CW'(1);
                    if (cnt_reg == '0) begin
                        rep_next   = 1'b1;
                        state_next = rep_reg ? ST_ACC : ST_LOAD;
                    end
                end
            end

            ST_DIV:
            begin
                sh_next  = SW'(div_quot);
                rem_next = div_rem[3:0];
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    // Remainder is the next decimal digit, least significant
                    // first; carry on with the quotient until it is zero.
                    stk_ctrl.push  = 1'b1;
                    stk_ctrl.digit = div_rem[3:0];
                    rem_next       = 4'd0;
                    cnt_next       = CW'(VB - 1);
                    if (div_quot == '0) begin
                        state_next = ST_POP;
                    end
                end
            end

            ST_POP:
            begin
                if (out_free) begin
                    ovalid_next  = 1'b1;
                    ochar_next   = ascii_of(stk_top);
                    obase_next   = BASE_DEC;
                    orend_next   = stk_last;
                    olast_next   = stk_last && rep_reg;
                    stk_ctrl.pop = 1'b1;
                    if (stk_last) begin
                        rep_next   = 1'b1;
                        state_next = rep_reg ? ST_ACC : ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_ACC;
            acc_reg    <= '0;
            rep_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            rep_reg    <= rep_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        sh_reg     <= sh_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        base_a_reg <= base_a_next;
        base_b_reg <= base_b_next;
        ochar_reg  <= ochar_next;
        obase_reg  <= obase_next;
        orend_reg  <= orend_next;
        olast_reg  <= olast_next;
    end

    assign s_axis_tready = (state_reg == ST_ACC);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tuser  = {orend_reg, obase_reg};
    assign m_axis_tlast  = olast_reg;

endmodule

`default_nettype wire

/* rtl/core/arc_dec_stack.sv */
`default_nettype none

// Last-in first-out store for decimal digits, built as a 4-bit wide shift
// register: a push shifts everything up one digit, a pop shifts it back.
module arc_dec_stack #(
    parameter int DEPTH = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire arc_pkg::stk_ctrl_t ctrl,
    output logic [3:0]             top,
    output logic                   last
);
    import arc_pkg::*;

    localparam int DW = DEPTH * 4;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;

    always_comb
    begin
        data_next  = data_reg;
        count_next = count_reg;
        if (ctrl.push) begin
            data_next  = {data_reg[DW-5:0], ctrl.digit};
            count_next = count_reg + NW'(1);
        end
        else if (ctrl.pop) begin
            data_next  = {4'b0000, data_reg[DW-1:4]};
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    assign top  = data_reg[3:0];
    assign last = (count_reg == NW'(1));

endmodule

`default_nettype wire
